### hdl/lcm_pkg.sv
// Shared types, mode codes and constant tables for the LED channel colour mixer.
// Used by lcm_chan_scale and led_channel_color_mixer; depends on nothing.
package lcm_pkg;

    typedef struct packed {
        logic       light_on;
        logic [3:0] mode;
        logic [7:0] level;
        logic [7:0] mode_arg;
    } cmd_t;

    typedef struct packed {
        logic [14:0] green_duty;
        logic [14:0] red_duty;
        logic [14:0] blue_duty;
    } result_t;

    localparam int DUTY_W   = 15;
    localparam int FACTOR_W = 9;     // 0..256, 256 passes the duty through

    localparam logic [3:0] MODE_GREEN = 4'd0;
    localparam logic [3:0] MODE_RED   = 4'd1;
    localparam logic [3:0] MODE_BLUE  = 4'd2;
    localparam logic [3:0] MODE_WHITE = 4'd3;
    localparam logic [3:0] MODE_BLEND = 4'd4;
    localparam logic [3:0] MODE_YELLOW = 4'd5;
    localparam logic [3:0] MODE_HUE   = 4'd6;
    localparam logic [3:0] MODE_CYAN  = 4'd7;
    localparam logic [3:0] MODE_CCT   = 4'd8;

    localparam logic [7:0] RAMP_TOP_LEVEL = 8'd149;
    localparam logic [8:0] K_PASS         = 9'd256;
    localparam logic [8:0] K_WHITE_GREEN  = 9'd105;
    localparam logic [8:0] K_YELLOW_GREEN = 9'd32;
    localparam logic [8:0] K_CYAN_GREEN   = 9'd128;
    localparam logic [7:0] HUE_SECTOR     = 8'd43;
    localparam logic [7:0] FULL8          = 8'd255;
    localparam logic [3:0] TEMP_LAST_IDX  = 4'd14;

    localparam logic [14:0] RAMP_TABLE [0:149] = '{
        15'd0, 15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd6, 15'd7, 15'd9, 15'd10,
        15'd12, 15'd14, 15'd17, 15'd19, 15'd22, 15'd25, 15'd28, 15'd32, 15'd36, 15'd41,
        15'd45, 15'd50, 15'd56, 15'd62, 15'd69, 15'd76, 15'd84, 15'd92, 15'd101, 15'd110,
        15'd121, 15'd132, 15'd143, 15'd156, 15'd169, 15'd184, 15'd199, 15'd215, 15'd232,
        15'd251, 15'd270, 15'd291, 15'd313, 15'd336, 15'd360, 15'd386, 15'd414, 15'd442,
        15'd473, 15'd505, 15'd539, 15'd574, 15'd612, 15'd651, 15'd693, 15'd736, 15'd782,
        15'd829, 15'd880, 15'd932, 15'd987, 15'd1045, 15'd1105, 15'd1168, 15'd1233,
        15'd1302, 15'd1374, 15'd1449, 15'd1527, 15'd1608, 15'd1693, 15'd1781, 15'd1873,
        15'd1969, 15'd2068, 15'd2172, 15'd2279, 15'd2391, 15'd2507, 15'd2628, 15'd2753,
        15'd2883, 15'd3018, 15'd3158, 15'd3303, 15'd3454, 15'd3609, 15'd3771, 15'd3938,
        15'd4111, 15'd4289, 15'd4475, 15'd4666, 15'd4864, 15'd5068, 15'd5280, 15'd5498,
        15'd5724, 15'd5957, 15'd6197, 15'd6445, 15'd6701, 15'd6965, 15'd7237, 15'd7518,
        15'd7808, 15'd8106, 15'd8413, 15'd8730, 15'd9056, 15'd9392, 15'd9737, 15'd10093,
        15'd10459, 15'd10835, 15'd11223, 15'd11621, 15'd12031, 15'd12452, 15'd12884,
        15'd13329, 15'd13786, 15'd14255, 15'd14737, 15'd15232, 15'd15741, 15'd16262,
        15'd16798, 15'd17347, 15'd17911, 15'd18489, 15'd19082, 15'd19691, 15'd20314,
        15'd20954, 15'd21609, 15'd22281, 15'd22969, 15'd23674, 15'd24397, 15'd25137,
        15'd25895, 15'd26671, 15'd27465, 15'd28279, 15'd29111, 15'd29963, 15'd30835,
        15'd31727, 15'd32640
    };

    // Colour temperature ratios, warm to daylight
    localparam logic [7:0] TEMP_RED [0:15] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };
    localparam logic [7:0] TEMP_GREEN [0:15] = '{
        8'd37, 8'd40, 8'd43, 8'd45, 8'd47, 8'd49, 8'd51, 8'd53,
        8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62
    };
    localparam logic [7:0] TEMP_BLUE [0:15] = '{
        8'd25, 8'd33, 8'd42, 8'd51, 8'd60, 8'd69, 8'd79, 8'd88,
        8'd97, 8'd106, 8'd114, 8'd123, 8'd131, 8'd139, 8'd146, 8'd153
    };

    // a + ((b - a) * frac) >> 8, with a negative step taken as zero
    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] frac);
        logic [7:0]  d;
        logic [15:0] p;
        d = (b >= a) ? 8'(b - a) : 8'd0;
        p = 16'(d) * 16'(frac);
        return 8'(a + p[15:8]);
    endfunction

    // 255 - ((255 * x) >> 8)
    function automatic logic [7:0] inv_scale(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'(FULL8);
        return 8'(FULL8 - p[15:8]);
    endfunction

endpackage

### hdl/lcm_chan_scale.sv
// One registered duty scaling stage: duty * factor / 256, truncated.
// Depends on lcm_pkg for widths.
module lcm_chan_scale (
    input  logic                          clk,
    input  logic [lcm_pkg::DUTY_W-1:0]    duty,
    input  logic [lcm_pkg::FACTOR_W-1:0]  factor,
    output logic [lcm_pkg::DUTY_W-1:0]    scaled
);

    localparam int PROD_W = lcm_pkg::DUTY_W + lcm_pkg::FACTOR_W;

    logic [PROD_W-1:0]         prod;
    logic [lcm_pkg::DUTY_W-1:0] scaled_reg;

    assign prod = PROD_W'(duty) * PROD_W'(factor);

    // factor never exceeds 256, so the product fits after the shift
    always_ff @(posedge clk)
    begin
        scaled_reg <= prod[lcm_pkg::DUTY_W+7:8];
    end

    assign scaled = scaled_reg;

endmodule

### hdl/led_channel_color_mixer.sv
// Top level of the LED channel colour mixer: ramp lookup, mode decode,
// per-channel scaling. Depends on lcm_pkg and lcm_chan_scale.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  command  | start in, busy out         | cmd    (lcm_pkg::cmd_t)
//  result   | result_valid strobe out    | result (lcm_pkg::result_t)
//
// Four register stages: ramp lookup and hue/temperature decode, channel
// factor selection, duty multiply, hue green trim. An accepted transaction
// passes through these stages in order and appears on result with
// result_valid; one is taken every cycle.
// busy stays low: the pipeline never stalls, as the receiver takes every
// result. Reset clears the stage valid bits only.
module led_channel_color_mixer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lcm_pkg::cmd_t       cmd,
    output logic                result_valid,
    output lcm_pkg::result_t    result
);

    // stage 1: lookup and decode
    logic        s1_valid_reg;
    logic        s1_on_reg;
    logic [3:0]  s1_mode_reg;
    logic [7:0]  s1_arg_reg;
    logic [14:0] s1_br_reg,     s1_br_next;
    logic [2:0]  s1_sector_reg, s1_sector_next;
    logic [7:0]  s1_rem_reg,    s1_rem_next;
    logic [3:0]  s1_idx_reg,    s1_idx_next;
    logic [7:0]  s1_frac_reg,   s1_frac_next;

    // stage 2: channel factors
    logic        s2_valid_reg;
    logic        s2_hue_reg;
    logic [14:0] s2_br_reg;
    logic [8:0]  s2_kg_reg, s2_kg_next;
    logic [8:0]  s2_kr_reg, s2_kr_next;
    logic [8:0]  s2_kb_reg, s2_kb_next;

    // stage 3: scaled duties
    logic        s3_valid_reg;
    logic        s3_hue_reg;
    logic [14:0] s3_g, s3_r, s3_b;

    // stage 4: output
    logic        s4_valid_reg;
    logic [14:0] s4_r_reg, s4_b_reg;
    logic [14:0] s4_g;
    logic [8:0]  green_trim;

    logic        accept;
    logic [7:0]  level_sat;
    logic [7:0]  hue_base;
    logic [7:0]  hue_diff;
    logic [11:0] cct_pos;
    logic [7:0]  kq, kt;
    logic [3:0]  idx_hi;
    logic [8:0]  cct_r, cct_g, cct_b;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---- stage 1 ----
    always_comb
    begin
        level_sat  = (cmd.level > lcm_pkg::RAMP_TOP_LEVEL) ? lcm_pkg::RAMP_TOP_LEVEL
                                                            : cmd.level;
        s1_br_next = lcm_pkg::RAMP_TABLE[level_sat];

        priority if (cmd.mode_arg < 8'd43)
        begin
            s1_sector_next = 3'd0;
            hue_base       = 8'd0;
        end
        else if (cmd.mode_arg < 8'd86)
        begin
            s1_sector_next = 3'd1;
            hue_base       = lcm_pkg::HUE_SECTOR;
        end
        else if (cmd.mode_arg < 8'd129)
        begin
            s1_sector_next = 3'd2;
            hue_base       = 8'd86;
        end
        else if (cmd.mode_arg < 8'd172)
        begin
            s1_sector_next = 3'd3;
            hue_base       = 8'd129;
        end
        else if (cmd.mode_arg < 8'd215)
        begin
            s1_sector_next = 3'd4;
            hue_base       = 8'd172;
        end
        else
        begin
            s1_sector_next = 3'd5;
            hue_base       = 8'd215;
        end
        hue_diff    = 8'(cmd.mode_arg - hue_base);
        s1_rem_next = 8'(hue_diff * 8'd6);

        // position = arg * 15; high nibble indexes, low byte interpolates
        cct_pos = 12'({cmd.mode_arg, 4'b0000}) - 12'(cmd.mode_arg);
        if (cct_pos[11:8] > lcm_pkg::TEMP_LAST_IDX)
        begin
            s1_idx_next  = lcm_pkg::TEMP_LAST_IDX;
            s1_frac_next = lcm_pkg::FULL8;
        end
        else
        begin
            s1_idx_next  = cct_pos[11:8];
            s1_frac_next = cct_pos[7:0];
        end
    end

    // ---- stage 2 ----
    always_comb
    begin
        kq     = lcm_pkg::inv_scale(s1_rem_reg);
        kt     = lcm_pkg::inv_scale(8'(lcm_pkg::FULL8 - s1_rem_reg));
        idx_hi = 4'(s1_idx_reg + 4'd1);
        cct_r  = 9'(lcm_pkg::lerp8(lcm_pkg::TEMP_RED[s1_idx_reg],
                                   lcm_pkg::TEMP_RED[idx_hi], s1_frac_reg));
        cct_g  = 9'(lcm_pkg::lerp8(lcm_pkg::TEMP_GREEN[s1_idx_reg],
                                   lcm_pkg::TEMP_GREEN[idx_hi], s1_frac_reg));
        cct_b  = 9'(lcm_pkg::lerp8(lcm_pkg::TEMP_BLUE[s1_idx_reg],
                                   lcm_pkg::TEMP_BLUE[idx_hi], s1_frac_reg));

        s2_kg_next = '0;
        s2_kr_next = '0;
        s2_kb_next = '0;
        if (s1_on_reg)
        begin
            unique case (s1_mode_reg)
                lcm_pkg::MODE_GREEN:  s2_kg_next = lcm_pkg::K_PASS;
                lcm_pkg::MODE_RED:    s2_kr_next = lcm_pkg::K_PASS;
                lcm_pkg::MODE_BLUE:   s2_kb_next = lcm_pkg::K_PASS;
                lcm_pkg::MODE_WHITE:
                begin
                    s2_kg_next = lcm_pkg::K_WHITE_GREEN;
                    s2_kr_next = lcm_pkg::K_PASS;
                    s2_kb_next = lcm_pkg::K_PASS;
                end
                lcm_pkg::MODE_BLEND:
                begin
                    s2_kr_next = 9'(lcm_pkg::FULL8 - s1_arg_reg);
                    s2_kb_next = 9'(s1_arg_reg);
                end
                lcm_pkg::MODE_YELLOW:
                begin
                    s2_kg_next = lcm_pkg::K_YELLOW_GREEN;
                    s2_kr_next = lcm_pkg::K_PASS;
                end
                lcm_pkg::MODE_HUE:
                begin
                    // full saturation: one channel full, one ramps, one off
                    unique case (s1_sector_reg)
                        3'd0:
                        begin
                            s2_kr_next = lcm_pkg::K_PASS;
                            s2_kg_next = 9'(kt);
                        end
                        3'd1:
                        begin
                            s2_kr_next = 9'(kq);
                            s2_kg_next = lcm_pkg::K_PASS;
                        end
                        3'd2:
                        begin
                            s2_kg_next = lcm_pkg::K_PASS;
                            s2_kb_next = 9'(kt);
                        end
                        3'd3:
                        begin
                            s2_kg_next = 9'(kq);
                            s2_kb_next = lcm_pkg::K_PASS;
                        end
                        3'd4:
                        begin
                            s2_kr_next = 9'(kt);
                            s2_kb_next = lcm_pkg::K_PASS;
                        end
                        default:
                        begin
                            s2_kr_next = lcm_pkg::K_PASS;
                            s2_kb_next = 9'(kq);
                        end
                    endcase
                end
                lcm_pkg::MODE_CYAN:
                begin
                    s2_kg_next = lcm_pkg::K_CYAN_GREEN;
                    s2_kb_next = lcm_pkg::K_PASS;
                end
                lcm_pkg::MODE_CCT:
                begin
                    s2_kr_next = cct_r;
                    s2_kg_next = cct_g;
                    s2_kb_next = cct_b;
                end
                default:
                begin
                    s2_kg_next = '0;
                end
            endcase
        end
    end

    // ---- stage 3: duty multiply ----
    lcm_chan_scale u_scale_g (.clk(clk), .duty(s2_br_reg), .factor(s2_kg_reg), .scaled(s3_g));
    lcm_chan_scale u_scale_r (.clk(clk), .duty(s2_br_reg), .factor(s2_kr_reg), .scaled(s3_r));
    lcm_chan_scale u_scale_b (.clk(clk), .duty(s2_br_reg), .factor(s2_kb_reg), .scaled(s3_b));

    // ---- stage 4: trim green in hue mode to balance its emitters ----
    assign green_trim = s3_hue_reg ? lcm_pkg::K_WHITE_GREEN : lcm_pkg::K_PASS;

    lcm_chan_scale u_trim_g (.clk(clk), .duty(s3_g), .factor(green_trim), .scaled(s4_g));

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_on_reg     <= cmd.light_on;
        s1_mode_reg   <= cmd.mode;
        s1_arg_reg    <= cmd.mode_arg;
        s1_br_reg     <= s1_br_next;
        s1_sector_reg <= s1_sector_next;
        s1_rem_reg    <= s1_rem_next;
        s1_idx_reg    <= s1_idx_next;
        s1_frac_reg   <= s1_frac_next;

        s2_br_reg     <= s1_br_reg;
        s2_hue_reg    <= (s1_mode_reg == lcm_pkg::MODE_HUE);
        s2_kg_reg     <= s2_kg_next;
        s2_kr_reg     <= s2_kr_next;
        s2_kb_reg     <= s2_kb_next;

        s3_hue_reg    <= s2_hue_reg;

        s4_r_reg      <= s3_r;
        s4_b_reg      <= s3_b;
    end

    assign result_valid      = s4_valid_reg;
    assign result.green_duty = s4_g;
    assign result.red_duty   = s4_r_reg;
    assign result.blue_duty  = s4_b_reg;

endmodule
